// ===== design/rls_pkg.sv =====
// Shared constants, register codes and arithmetic helpers for the recurrence line statistics block.
`timescale 1ns / 1ps

package rls_pkg;

    localparam int MAX_SIZE   = 256;
    localparam int SIZE_W     = $clog2(MAX_SIZE + 1);
    localparam int IDX_W      = $clog2(MAX_SIZE);
    localparam int DIAG_DEPTH = 2 * MAX_SIZE - 1;
    localparam int DADDR_W    = $clog2(DIAG_DEPTH);

    localparam int CFG_W      = 9;
    localparam int CFG_IDX_W  = 3;
    localparam int RUN_W      = 9;
    localparam int ACC_W      = 17;
    localparam int DLONG_W    = 8;
    localparam int RLONG_W    = 9;

    localparam int LEN_W_A    = (SIZE_W > CFG_W) ? SIZE_W : CFG_W;
    localparam int LEN_W      = (LEN_W_A > RUN_W) ? LEN_W_A : RUN_W;

    localparam logic [CFG_IDX_W-1:0] REG_MATRIX_SIZE = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_MIN_DIAG    = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_MIN_VERT    = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] REG_MIN_WHITE   = CFG_IDX_W'(3);

    localparam logic [CFG_W-1:0] RESET_MATRIX_SIZE = CFG_W'(256);
    localparam logic [CFG_W-1:0] RESET_MIN_DIAG    = CFG_W'(2);
    localparam logic [CFG_W-1:0] RESET_MIN_VERT    = CFG_W'(2);
    localparam logic [CFG_W-1:0] RESET_MIN_WHITE   = CFG_W'(1);

    // A size of zero acts as one, and a size above the maximum acts as the maximum.
    function automatic logic [SIZE_W-1:0] eff_size(input logic [CFG_W-1:0] v);
        logic [LEN_W-1:0] w;
        w = LEN_W'(v);
        if (v == '0) begin
            return SIZE_W'(1);
        end else if (w > LEN_W'(MAX_SIZE)) begin
            return SIZE_W'(MAX_SIZE);
        end
        return SIZE_W'(v);
    endfunction

    function automatic logic [ACC_W-1:0] sat_add(input logic [ACC_W-1:0] a,
                                                 input logic [ACC_W-1:0] b);
        logic [ACC_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[ACC_W] ? {ACC_W{1'b1}} : s[ACC_W-1:0];
    endfunction

    function automatic logic [LEN_W-1:0] max_len(input logic [LEN_W-1:0] a,
                                                 input logic [LEN_W-1:0] b);
        return (b > a) ? b : a;
    endfunction

endpackage

// ===== design/recurrence_line_statistics.sv =====
// Top level of the recurrence line statistics block: diagonal run memory and row run tracking.
`timescale 1ns / 1ps

// The block takes a square binary recurrence matrix one bit per word in row-major order and,
// after the last bit of a matrix has passed the stage-one registers, presents one result word
// with the recurrence count, the diagonal, vertical and white line weights, counts and longest
// lengths, and a flag for a matrix without any set bit off the main diagonal. It takes one bit
// every cycle: each bit makes one read and one write of the diagonal run memory, read in the
// cycle of acceptance and written back in the next. The last bit of a matrix is held off while
// the previous result is still waiting to be taken or is still being formed, so a one-by-one
// matrix takes no bit while its previous one is formed. A write of matrix_size abandons the
// matrix in progress; the minimum lengths apply to lines that end after they are written.
module recurrence_line_statistics
    import rls_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,

    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data,

    input  logic                 i_valid,
    output logic                 o_stall,
    input  logic                 i_recurrent_bit,

    output logic                 o_valid,
    input  logic                 i_stall,
    output logic [ACC_W-1:0]     o_recurrence_points,
    output logic [ACC_W-1:0]     o_diag_weight_min,
    output logic [ACC_W-1:0]     o_diag_weight_all,
    output logic [ACC_W-1:0]     o_diag_count_min,
    output logic [DLONG_W-1:0]   o_diag_longest,
    output logic [ACC_W-1:0]     o_vert_weight_min,
    output logic [ACC_W-1:0]     o_vert_count_min,
    output logic [RLONG_W-1:0]   o_vert_longest,
    output logic [ACC_W-1:0]     o_white_weight_min,
    output logic [ACC_W-1:0]     o_white_count_min,
    output logic [RLONG_W-1:0]   o_white_longest,
    output logic                 o_no_offdiag_error
);

    logic [RUN_W-1:0]   r_diag_mem [DIAG_DEPTH];

    logic [SIZE_W-1:0]  r_n;
    logic [IDX_W-1:0]   r_n_m1;
    logic [CFG_W-1:0]   r_min_diag;
    logic [CFG_W-1:0]   r_min_vert;
    logic [CFG_W-1:0]   r_min_white;

    logic [IDX_W-1:0]   r_row;
    logic [IDX_W-1:0]   r_col;

    logic               r_s1_valid;
    logic               r_s1_bit;
    logic               r_s1_first;
    logic               r_s1_col_last;
    logic               r_s1_edge;
    logic               r_s1_offd;
    logic               r_s1_last;
    logic [DADDR_W-1:0] r_s1_addr;
    logic [RUN_W-1:0]   r_rdata;

    logic [SIZE_W-1:0]  r_rec_run;
    logic [SIZE_W-1:0]  r_blank_run;
    logic [ACC_W-1:0]   r_points;
    logic [ACC_W-1:0]   r_dw_min;
    logic [ACC_W-1:0]   r_dw_all;
    logic [ACC_W-1:0]   r_dc_min;
    logic [ACC_W-1:0]   r_vw_min;
    logic [ACC_W-1:0]   r_vc_min;
    logic [ACC_W-1:0]   r_ww_min;
    logic [ACC_W-1:0]   r_wc_min;
    logic [RUN_W-1:0]   r_dlong;
    logic [SIZE_W-1:0]  r_vlong;
    logic [SIZE_W-1:0]  r_wlong;
    logic               r_offdiag;

    logic               r_out_valid;
    logic [ACC_W-1:0]   r_o_points;
    logic [ACC_W-1:0]   r_o_dw_min;
    logic [ACC_W-1:0]   r_o_dw_all;
    logic [ACC_W-1:0]   r_o_dc_min;
    logic [DLONG_W-1:0] r_o_dlong;
    logic [ACC_W-1:0]   r_o_vw_min;
    logic [ACC_W-1:0]   r_o_vc_min;
    logic [RLONG_W-1:0] r_o_vlong;
    logic [ACC_W-1:0]   r_o_ww_min;
    logic [ACC_W-1:0]   r_o_wc_min;
    logic [RLONG_W-1:0] r_o_wlong;
    logic               r_o_no_offd;

    logic               cfg_we;
    logic               size_we;
    logic               last_pos;
    logic               accept;
    logic               out_take;
    logic [DADDR_W-1:0] s1_addr;

    logic [RUN_W-1:0]   prev;
    logic [RUN_W:0]     inc;
    logic [RUN_W-1:0]   run;
    logic [RUN_W-1:0]   dlen;
    logic               d_end;
    logic               d_min;
    logic [RUN_W-1:0]   s2_wdata;
    logic [SIZE_W-1:0]  vend;
    logic [SIZE_W-1:0]  wend;
    logic               v_min;
    logic               w_min;

    logic [SIZE_W-1:0]  n_rec_run;
    logic [SIZE_W-1:0]  n_blank_run;
    logic [ACC_W-1:0]   n_points;
    logic [ACC_W-1:0]   n_dw_min;
    logic [ACC_W-1:0]   n_dw_all;
    logic [ACC_W-1:0]   n_dc_min;
    logic [ACC_W-1:0]   n_vw_min;
    logic [ACC_W-1:0]   n_vc_min;
    logic [ACC_W-1:0]   n_ww_min;
    logic [ACC_W-1:0]   n_wc_min;
    logic [RUN_W-1:0]   n_dlong;
    logic [SIZE_W-1:0]  n_vlong;
    logic [SIZE_W-1:0]  n_wlong;
    logic               n_offdiag;

    assign o_cfg_ready = 1'b1;
    assign cfg_we      = i_cfg_valid && o_cfg_ready;
    assign size_we     = cfg_we && (i_cfg_index == REG_MATRIX_SIZE);

    assign last_pos = (r_row == r_n_m1) && (r_col == r_n_m1);
    assign o_stall  = last_pos && ((r_out_valid && i_stall) || (r_s1_valid && r_s1_last));
    assign accept   = i_valid && !o_stall;
    assign out_take = r_out_valid && !i_stall;

    assign s1_addr = DADDR_W'(r_col) + DADDR_W'(r_n_m1) - DADDR_W'(r_row);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_n         <= eff_size(RESET_MATRIX_SIZE);
            r_n_m1      <= IDX_W'(eff_size(RESET_MATRIX_SIZE) - SIZE_W'(1));
            r_min_diag  <= RESET_MIN_DIAG;
            r_min_vert  <= RESET_MIN_VERT;
            r_min_white <= RESET_MIN_WHITE;
        end else if (cfg_we) begin
            unique case (i_cfg_index)
                REG_MATRIX_SIZE: begin
                    r_n    <= eff_size(i_cfg_data);
                    r_n_m1 <= IDX_W'(eff_size(i_cfg_data) - SIZE_W'(1));
                end
                REG_MIN_DIAG:  r_min_diag  <= i_cfg_data;
                REG_MIN_VERT:  r_min_vert  <= i_cfg_data;
                REG_MIN_WHITE: r_min_white <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || size_we) begin
            r_row <= '0;
            r_col <= '0;
        end else if (accept) begin
            if (r_col == r_n_m1) begin
                r_col <= '0;
                r_row <= (r_row == r_n_m1) ? '0 : r_row + IDX_W'(1);
            end else begin
                r_col <= r_col + IDX_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_bit      <= i_recurrent_bit;
            r_s1_first    <= (r_row == '0) || (r_col == '0);
            r_s1_col_last <= (r_col == r_n_m1);
            r_s1_edge     <= (r_col == r_n_m1) || (r_row == r_n_m1);
            r_s1_offd     <= (r_row != r_col);
            r_s1_last     <= last_pos;
            r_s1_addr     <= s1_addr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_s1_valid) begin
            r_diag_mem[r_s1_addr] <= s2_wdata;
        end
        r_rdata <= r_diag_mem[s1_addr];
    end

    always_comb begin
        prev  = r_s1_first ? '0 : r_rdata;
        inc   = {1'b0, prev} + (RUN_W + 1)'(1);
        run   = inc[RUN_W] ? {RUN_W{1'b1}} : inc[RUN_W-1:0];
        if (r_s1_bit) begin
            dlen     = r_s1_edge ? run : '0;
            s2_wdata = run;
        end else begin
            dlen     = prev;
            s2_wdata = '0;
        end
        d_end = (dlen != '0) && (LEN_W'(dlen) < LEN_W'(r_n));
        d_min = LEN_W'(dlen) >= LEN_W'(r_min_diag);

        vend        = '0;
        wend        = '0;
        n_rec_run   = r_rec_run;
        n_blank_run = r_blank_run;
        if (r_s1_bit) begin
            wend        = r_blank_run;
            n_blank_run = '0;
            n_rec_run   = r_rec_run + SIZE_W'(1);
            if (r_s1_col_last) begin
                vend      = n_rec_run;
                n_rec_run = '0;
            end
        end else begin
            vend        = r_rec_run;
            n_rec_run   = '0;
            n_blank_run = r_blank_run + SIZE_W'(1);
            if (r_s1_col_last) begin
                wend        = n_blank_run;
                n_blank_run = '0;
            end
        end
        v_min = (vend != '0) && (LEN_W'(vend) >= LEN_W'(r_min_vert));
        w_min = (wend != '0) && (LEN_W'(wend) >= LEN_W'(r_min_white));

        n_points  = r_s1_bit ? sat_add(r_points, ACC_W'(1)) : r_points;
        n_offdiag = r_offdiag || (r_s1_bit && r_s1_offd);

        n_dw_all = d_end ? sat_add(r_dw_all, ACC_W'(dlen)) : r_dw_all;
        n_dw_min = (d_end && d_min) ? sat_add(r_dw_min, ACC_W'(dlen)) : r_dw_min;
        n_dc_min = (d_end && d_min) ? sat_add(r_dc_min, ACC_W'(1)) : r_dc_min;
        n_dlong  = d_end ? RUN_W'(max_len(LEN_W'(r_dlong), LEN_W'(dlen))) : r_dlong;

        n_vw_min = v_min ? sat_add(r_vw_min, ACC_W'(vend)) : r_vw_min;
        n_vc_min = v_min ? sat_add(r_vc_min, ACC_W'(1)) : r_vc_min;
        n_vlong  = SIZE_W'(max_len(LEN_W'(r_vlong), LEN_W'(vend)));

        n_ww_min = w_min ? sat_add(r_ww_min, ACC_W'(wend)) : r_ww_min;
        n_wc_min = w_min ? sat_add(r_wc_min, ACC_W'(1)) : r_wc_min;
        n_wlong  = SIZE_W'(max_len(LEN_W'(r_wlong), LEN_W'(wend)));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || size_we || (r_s1_valid && r_s1_last)) begin
            r_rec_run   <= '0;
            r_blank_run <= '0;
            r_points    <= '0;
            r_dw_min    <= '0;
            r_dw_all    <= '0;
            r_dc_min    <= '0;
            r_vw_min    <= '0;
            r_vc_min    <= '0;
            r_ww_min    <= '0;
            r_wc_min    <= '0;
            r_dlong     <= '0;
            r_vlong     <= '0;
            r_wlong     <= '0;
            r_offdiag   <= 1'b0;
        end else if (r_s1_valid) begin
            r_rec_run   <= n_rec_run;
            r_blank_run <= n_blank_run;
            r_points    <= n_points;
            r_dw_min    <= n_dw_min;
            r_dw_all    <= n_dw_all;
            r_dc_min    <= n_dc_min;
            r_vw_min    <= n_vw_min;
            r_vc_min    <= n_vc_min;
            r_ww_min    <= n_ww_min;
            r_wc_min    <= n_wc_min;
            r_dlong     <= n_dlong;
            r_vlong     <= n_vlong;
            r_wlong     <= n_wlong;
            r_offdiag   <= n_offdiag;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_s1_valid && r_s1_last) begin
            r_out_valid <= 1'b1;
        end else if (out_take) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_s1_valid && r_s1_last) begin
            r_o_points  <= n_points;
            r_o_dw_min  <= n_dw_min;
            r_o_dw_all  <= n_dw_all;
            r_o_dc_min  <= n_dc_min;
            r_o_dlong   <= (LEN_W'(n_dlong) > LEN_W'({DLONG_W{1'b1}})) ?
                           {DLONG_W{1'b1}} : DLONG_W'(n_dlong);
            r_o_vw_min  <= n_vw_min;
            r_o_vc_min  <= n_vc_min;
            r_o_vlong   <= (LEN_W'(n_vlong) > LEN_W'({RLONG_W{1'b1}})) ?
                           {RLONG_W{1'b1}} : RLONG_W'(n_vlong);
            r_o_ww_min  <= n_ww_min;
            r_o_wc_min  <= n_wc_min;
            r_o_wlong   <= (LEN_W'(n_wlong) > LEN_W'({RLONG_W{1'b1}})) ?
                           {RLONG_W{1'b1}} : RLONG_W'(n_wlong);
            r_o_no_offd <= !n_offdiag;
        end
    end

    assign o_valid            = r_out_valid;
    assign o_recurrence_points = r_o_points;
    assign o_diag_weight_min  = r_o_dw_min;
    assign o_diag_weight_all  = r_o_dw_all;
    assign o_diag_count_min   = r_o_dc_min;
    assign o_diag_longest     = r_o_dlong;
    assign o_vert_weight_min  = r_o_vw_min;
    assign o_vert_count_min   = r_o_vc_min;
    assign o_vert_longest     = r_o_vlong;
    assign o_white_weight_min = r_o_ww_min;
    assign o_white_count_min  = r_o_wc_min;
    assign o_white_longest    = r_o_wlong;
    assign o_no_offdiag_error = r_o_no_offd;

`ifndef NO_ASSERTIONS
    // A finishing matrix must never land on a result that is still waiting.
    a_no_result_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && r_s1_last) |-> !(r_out_valid && i_stall))
        else $error("result register overwritten while stalled");

    // The last bit of a matrix produces a result in the following cycle.
    a_result_follows_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && r_s1_last) |=> o_valid)
        else $error("no result after the last bit of a matrix");

    // A new result appears only when a matrix has just finished.
    a_result_has_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(r_s1_valid && r_s1_last))
        else $error("result appeared without a finished matrix");

    // A read whose data is used never meets the write-back of the same diagonal.
    a_no_memory_collision: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && r_s1_valid && (r_n > SIZE_W'(1)) && (r_row != '0) && (r_col != '0))
        |-> (s1_addr != r_s1_addr))
        else $error("diagonal memory read and write collide");

    // The position stays inside the matrix in use.
    a_position_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |-> ((r_row <= r_n_m1) && (r_col <= r_n_m1)))
        else $error("matrix position out of range");
`endif

endmodule

// ===== verif/recurrence_line_statistics_tb.sv =====
// Self-checking testbench for the recurrence line statistics block with a line predictor.
`timescale 1ns / 1ps

module recurrence_line_statistics_tb;
    import rls_pkg::*;

    localparam int IDLE_PCT      = 32;
    localparam int RANDOM_ITEMS  = 500;
    localparam int SETTLE_CYCLES = 8;
    localparam int CYCLE_LIMIT   = 1000000;
    localparam int CALM_SIZE     = 16;
    localparam int CLAMP_CELLS   = 64;
    localparam int CODA_SIZE     = 4;
    localparam int REG_FIRST_UNUSED = int'(REG_MIN_WHITE) + 1;

    localparam int unsigned ACC_MAX   = (1 << ACC_W) - 1;
    localparam int unsigned RUN_MAX   = (1 << RUN_W) - 1;
    localparam int unsigned DLONG_MAX = (1 << DLONG_W) - 1;

    typedef enum int {
        PAT_ZEROS,
        PAT_ONES,
        PAT_IDENT,
        PAT_ANTI,
        PAT_BAND,
        PAT_MAIN_ONLY,
        PAT_NOISE
    } t_pattern;

    typedef struct packed {
        logic [ACC_W-1:0]   points;
        logic [ACC_W-1:0]   dw_min;
        logic [ACC_W-1:0]   dw_all;
        logic [ACC_W-1:0]   dc_min;
        logic [DLONG_W-1:0] d_long;
        logic [ACC_W-1:0]   vw_min;
        logic [ACC_W-1:0]   vc_min;
        logic [RLONG_W-1:0] v_long;
        logic [ACC_W-1:0]   ww_min;
        logic [ACC_W-1:0]   wc_min;
        logic [RLONG_W-1:0] w_long;
        logic               no_offdiag;
    } t_stats;

    typedef struct {
        logic [CFG_IDX_W-1:0] idx;
        logic [CFG_W-1:0]     data;
    } t_reg_write;

    typedef struct {
        logic [CFG_W-1:0] size;
        logic [CFG_W-1:0] min_d;
        logic [CFG_W-1:0] min_v;
        logic [CFG_W-1:0] min_w;
        t_pattern         kind;
        bit               typed;
        t_stats           want;
    } t_directed_row;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [CFG_W-1:0]     i_cfg_data = '0;
    logic                 i_valid = 1'b0;
    logic                 o_stall;
    logic                 i_recurrent_bit = 1'b0;
    logic                 o_valid;
    logic                 i_stall = 1'b0;
    logic [ACC_W-1:0]     o_recurrence_points;
    logic [ACC_W-1:0]     o_diag_weight_min;
    logic [ACC_W-1:0]     o_diag_weight_all;
    logic [ACC_W-1:0]     o_diag_count_min;
    logic [DLONG_W-1:0]   o_diag_longest;
    logic [ACC_W-1:0]     o_vert_weight_min;
    logic [ACC_W-1:0]     o_vert_count_min;
    logic [RLONG_W-1:0]   o_vert_longest;
    logic [ACC_W-1:0]     o_white_weight_min;
    logic [ACC_W-1:0]     o_white_count_min;
    logic [RLONG_W-1:0]   o_white_longest;
    logic                 o_no_offdiag_error;

    recurrence_line_statistics u_top (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_valid        (i_cfg_valid),
        .o_cfg_ready        (o_cfg_ready),
        .i_cfg_index        (i_cfg_index),
        .i_cfg_data         (i_cfg_data),
        .i_valid            (i_valid),
        .o_stall            (o_stall),
        .i_recurrent_bit    (i_recurrent_bit),
        .o_valid            (o_valid),
        .i_stall            (i_stall),
        .o_recurrence_points(o_recurrence_points),
        .o_diag_weight_min  (o_diag_weight_min),
        .o_diag_weight_all  (o_diag_weight_all),
        .o_diag_count_min   (o_diag_count_min),
        .o_diag_longest     (o_diag_longest),
        .o_vert_weight_min  (o_vert_weight_min),
        .o_vert_count_min   (o_vert_count_min),
        .o_vert_longest     (o_vert_longest),
        .o_white_weight_min (o_white_weight_min),
        .o_white_count_min  (o_white_count_min),
        .o_white_longest    (o_white_longest),
        .o_no_offdiag_error (o_no_offdiag_error)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    t_stats expected_stats[$];
    int     mismatches = 0;
    int     cycle_count = 0;
    bit     calm = 1'b0;

    // Line statistics predictor state.
    logic [CFG_W-1:0]   size_reg;
    logic [CFG_W-1:0]   min_diag_reg;
    logic [CFG_W-1:0]   min_vert_reg;
    logic [CFG_W-1:0]   min_white_reg;
    logic [RUN_W-1:0]   diag_run_mem [DIAG_DEPTH];
    int unsigned        row_pos;
    int unsigned        col_pos;
    int unsigned        set_run;
    int unsigned        clear_run;
    logic [ACC_W-1:0]   n_points, n_dw_min, n_dw_all, n_dc_min;
    logic [ACC_W-1:0]   n_vw_min, n_vc_min, n_ww_min, n_wc_min;
    int unsigned        long_diag, long_vert, long_white;
    bit                 offdiag_hit;

    function automatic logic [ACC_W-1:0] acc_plus(input logic [ACC_W-1:0] a, input int unsigned v);
        int unsigned s;
        s = int'(a) + v;
        return (s > ACC_MAX) ? ACC_W'(ACC_MAX) : ACC_W'(s);
    endfunction

    function automatic int unsigned live_size();
        if (size_reg == '0) return 1;
        if (int'(size_reg) > MAX_SIZE) return MAX_SIZE;
        return int'(size_reg);
    endfunction

    function automatic void clear_matrix();
        row_pos = 0;
        col_pos = 0;
        set_run = 0;
        clear_run = 0;
        n_points = '0;
        n_dw_min = '0;
        n_dw_all = '0;
        n_dc_min = '0;
        n_vw_min = '0;
        n_vc_min = '0;
        n_ww_min = '0;
        n_wc_min = '0;
        long_diag = 0;
        long_vert = 0;
        long_white = 0;
        offdiag_hit = 1'b0;
    endfunction

    function automatic void reset_predictor();
        size_reg = RESET_MATRIX_SIZE;
        min_diag_reg = RESET_MIN_DIAG;
        min_vert_reg = RESET_MIN_VERT;
        min_white_reg = RESET_MIN_WHITE;
        foreach (diag_run_mem[k]) diag_run_mem[k] = '0;
        clear_matrix();
    endfunction

    function automatic void apply_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        case (idx)
            REG_MATRIX_SIZE: begin
                size_reg = data;
                clear_matrix();
            end
            REG_MIN_DIAG:  min_diag_reg = data;
            REG_MIN_VERT:  min_vert_reg = data;
            REG_MIN_WHITE: min_white_reg = data;
            default: ;
        endcase
    endfunction

    function automatic void close_diagonal(input int unsigned len, input int unsigned n);
        if (len == 0 || len >= n) return;
        n_dw_all = acc_plus(n_dw_all, len);
        if (len >= int'(min_diag_reg)) begin
            n_dw_min = acc_plus(n_dw_min, len);
            n_dc_min = acc_plus(n_dc_min, 1);
        end
        if (len > long_diag) long_diag = len;
    endfunction

    function automatic void close_set_run(input int unsigned len);
        if (len == 0) return;
        if (len >= int'(min_vert_reg)) begin
            n_vw_min = acc_plus(n_vw_min, len);
            n_vc_min = acc_plus(n_vc_min, 1);
        end
        if (len > long_vert) long_vert = len;
    endfunction

    function automatic void close_clear_run(input int unsigned len);
        if (len == 0) return;
        if (len >= int'(min_white_reg)) begin
            n_ww_min = acc_plus(n_ww_min, len);
            n_wc_min = acc_plus(n_wc_min, 1);
        end
        if (len > long_white) long_white = len;
    endfunction

    task automatic tally_bit(input logic b, output bit done, output t_stats r);
        int unsigned n, i, j, d, prev, run;
        n = live_size();
        done = 1'b0;
        r = '0;
        if (row_pos >= n || col_pos >= n) begin
            row_pos = 0;
            col_pos = 0;
        end
        i = row_pos;
        j = col_pos;
        if (b) begin
            n_points = acc_plus(n_points, 1);
            if (i != j) offdiag_hit = 1'b1;
        end
        d = j + (n - 1) - i;
        if (d >= DIAG_DEPTH) d = DIAG_DEPTH - 1;
        prev = (i > 0 && j > 0) ? int'(diag_run_mem[d]) : 0;
        if (b) begin
            run = prev + 1;
            if (run > RUN_MAX) run = RUN_MAX;
            if (i == n - 1 || j == n - 1) close_diagonal(run, n);
            diag_run_mem[d] = RUN_W'(run);
        end else begin
            close_diagonal(prev, n);
            diag_run_mem[d] = '0;
        end
        if (b) begin
            close_clear_run(clear_run);
            clear_run = 0;
            set_run++;
        end else begin
            close_set_run(set_run);
            set_run = 0;
            clear_run++;
        end
        if (j == n - 1) begin
            close_set_run(set_run);
            close_clear_run(clear_run);
            set_run = 0;
            clear_run = 0;
        end
        col_pos = j + 1;
        if (col_pos >= n) begin
            col_pos = 0;
            row_pos = i + 1;
            if (row_pos >= n) begin
                r.points = n_points;
                r.dw_min = n_dw_min;
                r.dw_all = n_dw_all;
                r.dc_min = n_dc_min;
                r.d_long = (long_diag > DLONG_MAX) ? DLONG_W'(DLONG_MAX) : DLONG_W'(long_diag);
                r.vw_min = n_vw_min;
                r.vc_min = n_vc_min;
                r.v_long = RLONG_W'(long_vert);
                r.ww_min = n_ww_min;
                r.wc_min = n_wc_min;
                r.w_long = RLONG_W'(long_white);
                r.no_offdiag = !offdiag_hit;
                done = 1'b1;
                clear_matrix();
            end
        end
    endtask

    function automatic t_stats typed_stats(input int pts, input int vlong, input int ww,
                                           input int wc, input int wlong, input bit flag);
        t_stats s;
        s = '0;
        s.points = ACC_W'(pts);
        s.v_long = RLONG_W'(vlong);
        s.ww_min = ACC_W'(ww);
        s.wc_min = ACC_W'(wc);
        s.w_long = RLONG_W'(wlong);
        s.no_offdiag = flag;
        return s;
    endfunction

    function automatic logic cell_value(input t_pattern kind, input int dens, input int i,
                                        input int j, input int n);
        case (kind)
            PAT_ZEROS:     return 1'b0;
            PAT_ONES:      return 1'b1;
            PAT_IDENT:     return i == j;
            PAT_ANTI:      return i + j == n - 1;
            PAT_BAND:      return (i == j || i == j + 1 || j == i + 1) && $urandom_range(99) < dens;
            PAT_MAIN_ONLY: return i == j && $urandom_range(99) < dens;
            default:       return $urandom_range(99) < dens;
        endcase
    endfunction

    function automatic logic [CFG_W-1:0] pick_size();
        int sel;
        sel = $urandom_range(99);
        if (sel < 4) return '0;
        if (sel < 55) return CFG_W'($urandom_range(5, 1));
        if (sel < 92) return CFG_W'($urandom_range(10, 6));
        return CFG_W'($urandom_range(16, 11));
    endfunction

    function automatic logic [CFG_W-1:0] pick_min(input int n);
        case ($urandom_range(9))
            0:       return '0;
            1:       return CFG_W'(1);
            2:       return CFG_W'(2);
            3:       return CFG_W'(n);
            4:       return CFG_W'(n + 1);
            5:       return CFG_W'(MAX_SIZE);
            6:       return '1;
            default: return CFG_W'($urandom_range(n + 1, 1));
        endcase
    endfunction

    function automatic t_pattern pick_pattern();
        int sel;
        sel = $urandom_range(99);
        if (sel < 55) return PAT_NOISE;
        if (sel < 65) return PAT_BAND;
        if (sel < 72) return PAT_MAIN_ONLY;
        if (sel < 80) return PAT_ONES;
        if (sel < 87) return PAT_ZEROS;
        if (sel < 93) return PAT_IDENT;
        return PAT_ANTI;
    endfunction

    task automatic write_regs(input t_reg_write w[$]);
        for (int k = 0; k < w.size(); k++) begin
            i_cfg_valid <= 1'b1;
            i_cfg_index <= w[k].idx;
            i_cfg_data <= w[k].data;
            do @(posedge i_clk); while (!o_cfg_ready);
            apply_reg(w[k].idx, w[k].data);
        end
        i_cfg_valid <= 1'b0;
    endtask

    task automatic await_idle();
        i_valid <= 1'b0;
        while (expected_stats.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic send_cells(input t_pattern kind, input int dens, input int first,
                              input int count, input bit typed, input t_stats want);
        int     n;
        bit     done;
        t_stats got;
        logic   b;
        n = live_size();
        for (int c = first; c < first + count; c++) begin
            b = cell_value(kind, dens, c / n, c % n, n);
            while (!calm && $urandom_range(99) < IDLE_PCT) begin
                i_valid <= 1'b0;
                @(posedge i_clk);
            end
            i_valid <= 1'b1;
            i_recurrent_bit <= b;
            do @(posedge i_clk); while (o_stall);
            tally_bit(b, done, got);
            if (done) begin
                expected_stats.push_back(typed ? want : got);
            end
        end
    endtask

    function automatic void check_field(input string name, input int unsigned want,
                                        input int unsigned got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endfunction

    always @(posedge i_clk) begin : result_monitor
        t_stats want;
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            if (o_valid && !i_stall) begin
                if (expected_stats.size() == 0) begin
                    $error("result word with no expectation pending");
                    mismatches++;
                end else begin
                    want = expected_stats.pop_front();
                    check_field("recurrence_points", want.points, o_recurrence_points);
                    check_field("diag_weight_min", want.dw_min, o_diag_weight_min);
                    check_field("diag_weight_all", want.dw_all, o_diag_weight_all);
                    check_field("diag_count_min", want.dc_min, o_diag_count_min);
                    check_field("diag_longest", want.d_long, o_diag_longest);
                    check_field("vert_weight_min", want.vw_min, o_vert_weight_min);
                    check_field("vert_count_min", want.vc_min, o_vert_count_min);
                    check_field("vert_longest", want.v_long, o_vert_longest);
                    check_field("white_weight_min", want.ww_min, o_white_weight_min);
                    check_field("white_count_min", want.wc_min, o_white_count_min);
                    check_field("white_longest", want.w_long, o_white_longest);
                    check_field("no_offdiag_error", want.no_offdiag, o_no_offdiag_error);
                end
            end
            i_stall <= !calm && ($urandom_range(99) < IDLE_PCT);
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("recurrence_line_statistics_tb failed");
            $finish;
        end
    end

    initial begin : stimulus
        t_reg_write    regs[$];
        t_directed_row rows[6];
        t_pattern      kind;
        int            n, total, cut, dens, random_items;

        rows[0] = '{CFG_W'(1), CFG_W'(2), CFG_W'(2), CFG_W'(1), PAT_ONES, 1'b1,
                    typed_stats(1, 1, 0, 0, 0, 1'b1)};
        rows[1] = '{CFG_W'(1), CFG_W'(2), CFG_W'(2), CFG_W'(1), PAT_ZEROS, 1'b1,
                    typed_stats(0, 0, 1, 1, 1, 1'b1)};
        rows[2] = '{CFG_W'(0), CFG_W'(2), CFG_W'(2), CFG_W'(1), PAT_ONES, 1'b1,
                    typed_stats(1, 1, 0, 0, 0, 1'b1)};
        rows[3] = '{CFG_W'(2), CFG_W'(1), CFG_W'(1), CFG_W'(1), PAT_ANTI, 1'b0, '0};
        rows[4] = '{CFG_W'(3), CFG_W'(2), CFG_W'(2), CFG_W'(1), PAT_IDENT, 1'b1,
                    typed_stats(3, 1, 6, 4, 2, 1'b1)};
        rows[5] = '{CFG_W'(3), CFG_W'(1), CFG_W'(1), CFG_W'(1), PAT_ONES, 1'b0, '0};

        reset_predictor();
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (rows[r]) begin
            regs = {};
            regs.push_back('{REG_MATRIX_SIZE, rows[r].size});
            regs.push_back('{REG_MIN_DIAG, rows[r].min_d});
            regs.push_back('{REG_MIN_VERT, rows[r].min_v});
            regs.push_back('{REG_MIN_WHITE, rows[r].min_w});
            await_idle();
            write_regs(regs);
            n = live_size();
            send_cells(rows[r].kind, 50, 0, n * n, rows[r].typed, rows[r].want);
        end

        random_items = 0;
        while (random_items < RANDOM_ITEMS) begin
            if (random_items == 0 || $urandom_range(99) < 40) begin
                regs = {};
                if (random_items == 0 || $urandom_range(1) == 0)
                    regs.push_back('{REG_MATRIX_SIZE, pick_size()});
                if ($urandom_range(1) == 0) regs.push_back('{REG_MIN_DIAG, pick_min(16)});
                if ($urandom_range(1) == 0) regs.push_back('{REG_MIN_VERT, pick_min(16)});
                if ($urandom_range(1) == 0) regs.push_back('{REG_MIN_WHITE, pick_min(16)});
                if ($urandom_range(9) == 0)
                    regs.push_back('{CFG_IDX_W'(REG_FIRST_UNUSED + $urandom_range(3)),
                                     CFG_W'($urandom)});
                await_idle();
                write_regs(regs);
            end
            n = live_size();
            total = n * n;
            kind = pick_pattern();
            dens = $urandom_range(95, 5);
            cut = ($urandom_range(99) < 12 && total > 1) ? $urandom_range(total - 1, 1) : total;
            send_cells(kind, dens, 0, cut, 1'b0, '0);
            random_items += cut;
            if (cut < total) begin
                await_idle();
                regs = {};
                if ($urandom_range(1) == 0) begin
                    // A new size abandons the partial matrix.
                    regs.push_back('{REG_MATRIX_SIZE, pick_size()});
                    write_regs(regs);
                end else begin
                    regs.push_back('{CFG_IDX_W'(int'(REG_MIN_DIAG) + $urandom_range(2)),
                                     pick_min(n)});
                    write_regs(regs);
                    send_cells(kind, dens, cut, total - cut, 1'b0, '0);
                    random_items += total - cut;
                end
            end
        end

        await_idle();
        calm = 1'b1;
        regs = {};
        regs.push_back('{REG_MATRIX_SIZE, CFG_W'(CALM_SIZE)});
        regs.push_back('{REG_MIN_DIAG, CFG_W'(CALM_SIZE - 1)});
        regs.push_back('{REG_MIN_VERT, CFG_W'(CALM_SIZE)});
        regs.push_back('{REG_MIN_WHITE, '1});
        write_regs(regs);
        send_cells(PAT_ONES, 0, 0, CALM_SIZE * CALM_SIZE, 1'b0, '0);

        await_idle();
        calm = 1'b0;
        regs = {};
        regs.push_back('{REG_MATRIX_SIZE, '1});
        regs.push_back('{REG_MIN_DIAG, '0});
        regs.push_back('{REG_MIN_VERT, CFG_W'(1)});
        regs.push_back('{REG_MIN_WHITE, CFG_W'(3)});
        write_regs(regs);
        send_cells(PAT_NOISE, 50, 0, CLAMP_CELLS, 1'b0, '0);

        // A new size abandons the partial matrix at the largest size.
        await_idle();
        regs = {};
        regs.push_back('{REG_MATRIX_SIZE, CFG_W'(CODA_SIZE)});
        write_regs(regs);
        send_cells(PAT_NOISE, 50, 0, CODA_SIZE * CODA_SIZE, 1'b0, '0);

        await_idle();
        if (mismatches == 0 && expected_stats.size() == 0) begin
            $display("recurrence_line_statistics_tb passed");
        end else begin
            $display("recurrence_line_statistics_tb failed");
        end
        $finish;
    end

endmodule
